>>> rtl/core/fsoa_pkg.sv
// Package for the fixed-size object allocator.
// Holds status codes, register indexes, bitmap row geometry and divider interface types.
// No dependencies.
package fsoa_pkg;

   localparam int ROW_BITS = 16;
   localparam int ROW_LSB  = 4;
   localparam int CNT_W    = 7;
   localparam int ROWCNT_W = 4;
   localparam int ADDR_W   = 32;
   localparam int SIZE_W   = 16;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_DISABLED = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_BAD_ADDR = 3'd3;
   localparam logic [2:0] ST_NOT_USED = 3'd4;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [1:0] CSR_ENABLED      = 2'd0;
   localparam logic [1:0] CSR_BASE_ADDRESS = 2'd1;
   localparam logic [1:0] CSR_OBJECT_SIZE  = 2'd2;
   localparam logic [1:0] CSR_SLOT_COUNT   = 2'd3;

   typedef struct packed {
      logic              start;
      logic [ADDR_W-1:0] dividend;
      logic [SIZE_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [ADDR_W-1:0] quotient;
      logic [SIZE_W-1:0] remainder;
   } div_rsp_type;

   function automatic logic [2:0] popcount4(input logic [3:0] v);
      popcount4 = 3'(v[0]) + 3'(v[1]) + 3'(v[2]) + 3'(v[3]);
   endfunction

   function automatic logic [4:0] popcount16(input logic [ROW_BITS-1:0] v);
      logic [3:0] lo;
      logic [3:0] hi;
      lo = 4'(popcount4(v[3:0])) + 4'(popcount4(v[7:4]));
      hi = 4'(popcount4(v[11:8])) + 4'(popcount4(v[15:12]));
      popcount16 = 5'(lo) + 5'(hi);
   endfunction

endpackage

>>> rtl/core/fixed_size_object_allocator.sv
// Fixed-size object allocator: bitmap slab cache over one region of equal slots.
// Top level: configuration registers, request sequencer and result register.
// Depends on fsoa_pkg, fsoa_bitmap and fsoa_div.
//
// One request is in work at a time; req_tready is high only while the sequencer is
// idle. Each request first scans the used-bit memory, one row of 16 slots at a time
// (ceil(n/16) rows, n = effective slot count), to count free slots and find the
// lowest free one. An allocate then goes through an index times size multiply, an
// add and write-back, and a result load. A free runs the address offset through a
// serial divider started at acceptance, then reads and writes the slot's row. A result
// waits in the rsp register until taken; the used bits read as free after reset
// without a clearing pass.
module fixed_size_object_allocator #(
   parameter int MAX_SLOTS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] address
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [2:0] status, [34:3] object_address, [41:35] free_count
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int ROWS     = (MAX_SLOTS + fsoa_pkg::ROW_BITS - 1) / fsoa_pkg::ROW_BITS;
   localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int MAX_CLIP = (MAX_SLOTS > 127) ? 127 : MAX_SLOTS;
   localparam int CW       = fsoa_pkg::CNT_W;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SCAN_RD  = 4'd1;
   localparam logic [3:0] S_SCAN_DAT = 4'd2;
   localparam logic [3:0] S_MUL      = 4'd3;
   localparam logic [3:0] S_ALLOC_WR = 4'd4;
   localparam logic [3:0] S_WAIT_DIV = 4'd5;
   localparam logic [3:0] S_FREE_RD  = 4'd6;
   localparam logic [3:0] S_FREE_DAT = 4'd7;
   localparam logic [3:0] S_DONE     = 4'd8;

   // configuration
   logic        enabled_ff;
   logic [31:0] base_ff;
   logic [15:0] size_ff;
   logic [6:0]  slots_ff;
   logic [CW-1:0] n_eff;

   // sequencer
   logic [3:0]  state_ff, state_in;
   logic        kind_ff, kind_in;
   logic [31:0] addr_ff, addr_in;
   logic [CW-1:0] n_ff, n_in;
   logic [fsoa_pkg::ROWCNT_W-1:0] row_ff, row_in;
   logic [fsoa_pkg::ROWCNT_W-1:0] rows_ff, rows_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic        found_ff, found_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [fsoa_pkg::ROW_BITS-1:0] rowdat_ff, rowdat_in;
   logic [22:0] prod_ff, prod_in;
   logic [2:0]  status_ff, status_in;
   logic [31:0] obj_ff, obj_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;

   // memory and divider
   logic                          bm_rd_en;
   logic [ROW_W-1:0]              bm_rd_row;
   logic [fsoa_pkg::ROW_BITS-1:0] bm_rd_data;
   logic                          bm_wr_en;
   logic [ROW_W-1:0]              bm_wr_row;
   logic [fsoa_pkg::ROW_BITS-1:0] bm_wr_data;
   fsoa_pkg::div_req_type         div_req;
   fsoa_pkg::div_rsp_type         div_rsp;

   logic        req_fire;
   logic [7:0]  rows_sum;
   logic [fsoa_pkg::ROW_BITS-1:0] free_bits;
   logic [3:0]  low_pos;

   fsoa_bitmap #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W)
   ) u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (bm_rd_en),
      .rd_row  (bm_rd_row),
      .rd_data (bm_rd_data),
      .wr_en   (bm_wr_en),
      .wr_row  (bm_wr_row),
      .wr_data (bm_wr_data)
   );

   fsoa_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         base_ff    <= '0;
         size_ff    <= 16'd64;
         slots_ff   <= 7'd64;
      end else if (csr_we) begin
         unique case (csr_index)
            fsoa_pkg::CSR_ENABLED:      enabled_ff <= csr_wdata[0];
            fsoa_pkg::CSR_BASE_ADDRESS: base_ff    <= csr_wdata;
            fsoa_pkg::CSR_OBJECT_SIZE:  size_ff    <= csr_wdata[15:0];
            fsoa_pkg::CSR_SLOT_COUNT:   slots_ff   <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   assign n_eff      = (slots_ff < 7'(MAX_CLIP)) ? slots_ff : 7'(MAX_CLIP);
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rows_sum   = 8'(n_eff) + 8'd15;

   always_comb begin
      for (int j = 0; j < fsoa_pkg::ROW_BITS; j++) begin
         free_bits[j] = !bm_rd_data[j] && ({row_ff[2:0], 4'(j)} < n_ff);
      end
      low_pos = '0;
      for (int j = fsoa_pkg::ROW_BITS - 1; j >= 0; j--) begin
         if (free_bits[j]) begin
            low_pos = 4'(j);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      addr_in      = addr_ff;
      n_in         = n_ff;
      row_in       = row_ff;
      rows_in      = rows_ff;
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      idx_in       = idx_ff;
      rowdat_in    = rowdat_ff;
      prod_in      = prod_ff;
      status_in    = status_ff;
      obj_in       = obj_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      bm_rd_en     = 1'b0;
      bm_rd_row    = ROW_W'(row_ff);
      bm_wr_en     = 1'b0;
      bm_wr_row    = ROW_W'(idx_ff[6:4]);
      bm_wr_data   = rowdat_ff;
      div_req.start    = 1'b0;
      div_req.dividend = req_tdata - base_ff;
      div_req.divisor  = size_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in  = req_tuser;
               addr_in  = req_tdata;
               n_in     = n_eff;
               rows_in  = rows_sum[7:4];
               row_in   = '0;
               cnt_in   = '0;
               found_in = 1'b0;
               obj_in   = '0;
               div_req.start = enabled_ff && (req_tuser == fsoa_pkg::KIND_FREE);
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            if (row_ff == rows_ff) begin
               if (!enabled_ff) begin
                  status_in = fsoa_pkg::ST_DISABLED;
                  state_in  = S_DONE;
               end else if (kind_ff == fsoa_pkg::KIND_ALLOC) begin
                  if (found_ff) begin
                     state_in = S_MUL;
                  end else begin
                     status_in = fsoa_pkg::ST_FULL;
                     state_in  = S_DONE;
                  end
               end else begin
                  state_in = S_WAIT_DIV;
               end
            end else begin
               bm_rd_en = 1'b1;
               state_in = S_SCAN_DAT;
            end
         end
         S_SCAN_DAT: begin
            cnt_in = cnt_ff + CW'(fsoa_pkg::popcount16(free_bits));
            if (!found_ff && (free_bits != '0)) begin
               found_in  = 1'b1;
               idx_in    = {row_ff[2:0], low_pos};
               rowdat_in = bm_rd_data;
            end
            row_in   = row_ff + 1'b1;
            state_in = S_SCAN_RD;
         end
         S_MUL: begin
            prod_in  = idx_ff * size_ff;
            state_in = S_ALLOC_WR;
         end
         S_ALLOC_WR: begin
            bm_wr_en   = 1'b1;
            bm_wr_data = rowdat_ff | (fsoa_pkg::ROW_BITS'(1) << idx_ff[3:0]);
            obj_in     = base_ff + 32'(prod_ff);
            cnt_in     = cnt_ff - 1'b1;
            status_in  = fsoa_pkg::ST_OK;
            state_in   = S_DONE;
         end
         S_WAIT_DIV: begin
            if (div_rsp.done) begin
               if ((addr_ff == '0) || (size_ff == '0) || (div_rsp.remainder != '0)
                   || (div_rsp.quotient >= 32'(n_ff))) begin
                  status_in = fsoa_pkg::ST_BAD_ADDR;
                  state_in  = S_DONE;
               end else begin
                  idx_in   = div_rsp.quotient[CW-1:0];
                  state_in = S_FREE_RD;
               end
            end
         end
         S_FREE_RD: begin
            bm_rd_en  = 1'b1;
            bm_rd_row = ROW_W'(idx_ff[6:4]);
            state_in  = S_FREE_DAT;
         end
         S_FREE_DAT: begin
            if (!bm_rd_data[idx_ff[3:0]]) begin
               status_in = fsoa_pkg::ST_NOT_USED;
            end else begin
               bm_wr_en   = 1'b1;
               bm_wr_data = bm_rd_data & ~(fsoa_pkg::ROW_BITS'(1) << idx_ff[3:0]);
               cnt_in     = cnt_ff + 1'b1;
               status_in  = fsoa_pkg::ST_OK;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'd0, cnt_ff, obj_ff, status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      addr_ff     <= addr_in;
      n_ff        <= n_in;
      row_ff      <= row_in;
      rows_ff     <= rows_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      rowdat_ff   <= rowdat_in;
      prod_ff     <= prod_in;
      status_ff   <= status_in;
      obj_ff      <= obj_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ifndef SYNTHESIS
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_DONE) |-> !bm_wr_en)
      else $error("bitmap written outside a request");
   a_found_in_range: assert property (@(posedge clock) disable iff (reset)
      found_ff && state_ff != S_IDLE |-> idx_ff < n_ff)
      else $error("found slot beyond configured count");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL || state_ff == S_WAIT_DIV) |-> cnt_ff <= n_ff)
      else $error("free count exceeds configured count");
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_WAIT_DIV || state_ff == S_SCAN_RD
                        || state_ff == S_SCAN_DAT))
      else $error("divider finished outside a free request");
   `endif

endmodule

>>> rtl/core/fsoa_bitmap.sv
// Used-bit memory of the allocator: one row of fsoa_pkg::ROW_BITS slots per entry.
// One write and one registered read port; per-row valid bits make reset read as all free.
// Depends on fsoa_pkg.
module fsoa_bitmap #(
   parameter int ROWS  = 4,
   parameter int ROW_W = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [ROW_W-1:0]             rd_row,
   output logic [fsoa_pkg::ROW_BITS-1:0] rd_data,
   input  logic                         wr_en,
   input  logic [ROW_W-1:0]             wr_row,
   input  logic [fsoa_pkg::ROW_BITS-1:0] wr_data
);

   logic [fsoa_pkg::ROW_BITS-1:0] mem_ff [ROWS];
   logic [ROWS-1:0]               row_valid_ff;
   logic [fsoa_pkg::ROW_BITS-1:0] rd_data_ff;
   logic                          rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_row] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[wr_row] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= row_valid_ff[rd_row];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

>>> rtl/core/fsoa_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Divides the freed address offset by the object size.
// Depends on fsoa_pkg.
module fsoa_div (
   input  logic                  clock,
   input  logic                  reset,
   input  fsoa_pkg::div_req_type req,
   output fsoa_pkg::div_rsp_type rsp
);

   logic                          busy_ff;
   logic                          done_ff;
   logic [4:0]                    step_ff;
   logic [fsoa_pkg::ADDR_W-1:0]   quo_ff;
   logic [fsoa_pkg::SIZE_W-1:0]   rem_ff;
   logic [fsoa_pkg::SIZE_W-1:0]   dvs_ff;
   logic [fsoa_pkg::SIZE_W:0]     shifted;
   logic                          fits;
   logic [fsoa_pkg::SIZE_W:0]     diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[fsoa_pkg::ADDR_W-1]};
      fits    = shifted >= {1'b0, dvs_ff};
      diff    = shifted - {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff <= req.dividend;
         rem_ff <= '0;
         dvs_ff <= req.divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[fsoa_pkg::ADDR_W-2:0], fits};
         rem_ff <= fits ? diff[fsoa_pkg::SIZE_W-1:0] : shifted[fsoa_pkg::SIZE_W-1:0];
      end
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

   `ifndef SYNTHESIS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff && step_ff != 5'd31 |-> !req.start)
      else $error("divider restarted while busy");
   `endif

endmodule

>>> verif/fixed_size_object_allocator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for fixed_size_object_allocator: allocate/free streams under random
// idling and back-pressure, checked against a bitmap cache predictor kept in step with it.
// Depends on fsoa_pkg and the allocator RTL.
module fixed_size_object_allocator_test;

   localparam int SLOTS      = 64;
   localparam int STALL_WALL = 3000;

   typedef struct {
      logic        kind;
      logic [31:0] address;
   } cache_request_type;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] object_address;
      logic [6:0]  free_count;
   } cache_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] address
   logic        req_tuser = 1'b0; // [0] kind
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // [2:0] status, [34:3] object_address, [41:35] free_count
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   cache_request_type cache_requests[$];
   cache_result_type  expected_results[$];

   // predictor copy of the cache
   logic        slot_taken[SLOTS];
   logic        cache_on = 1'b0;
   logic [31:0] region_base = '0;
   logic [15:0] slot_bytes = 16'd64;
   logic [6:0]  slot_limit = 7'd64;

   bit          idling_on = 1'b1;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned mismatches = 0;

   fixed_size_object_allocator #(.MAX_SLOTS(SLOTS)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int unsigned live_slots();
      return (slot_limit < SLOTS) ? slot_limit : SLOTS;
   endfunction

   function automatic logic [6:0] free_in_range();
      logic [6:0] k;
      k = '0;
      for (int i = 0; i < live_slots(); i++)
         if (!slot_taken[i]) k++;
      return k;
   endfunction

   function automatic cache_result_type predict_cache_result(logic kind, logic [31:0] address);
      cache_result_type r;
      logic [31:0]      offset;
      logic [31:0]      index;
      bit               found;
      r.status = fsoa_pkg::ST_OK;
      r.object_address = '0;
      found = 0;
      if (!cache_on) begin
         r.status = fsoa_pkg::ST_DISABLED;
      end else if (kind == fsoa_pkg::KIND_ALLOC) begin
         r.status = fsoa_pkg::ST_FULL;
         for (int i = 0; i < live_slots(); i++) begin
            if (!found && !slot_taken[i]) begin
               found = 1;
               slot_taken[i] = 1'b1;
               r.object_address = region_base + 32'(i) * 32'(slot_bytes);
               r.status = fsoa_pkg::ST_OK;
            end
         end
      end else begin
         offset = address - region_base;
         if (address == '0 || slot_bytes == '0 || (offset % {16'd0, slot_bytes}) != '0) begin
            r.status = fsoa_pkg::ST_BAD_ADDR;
         end else begin
            index = offset / {16'd0, slot_bytes};
            if (index >= live_slots())
               r.status = fsoa_pkg::ST_BAD_ADDR;
            else if (!slot_taken[index])
               r.status = fsoa_pkg::ST_NOT_USED;
            else
               slot_taken[index] = 1'b0;
         end
      end
      r.free_count = free_in_range();
      return r;
   endfunction

   function automatic int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic cache_request_type random_request();
      cache_request_type r;
      int unsigned       pick;
      int unsigned       n;
      n = live_slots();
      pick = $urandom_range(0, 99);
      r.address = $urandom;
      r.kind = fsoa_pkg::KIND_ALLOC;
      if (pick >= 50) begin
         r.kind = fsoa_pkg::KIND_FREE;
         if (pick < 85 && n > 0)
            r.address = region_base + 32'($urandom_range(0, n - 1)) * 32'(slot_bytes);
         else if (pick < 90)
            r.address = region_base + 32'($urandom_range(0, n + 3)) * 32'(slot_bytes)
                        + 32'($urandom_range(1, 3));
         else if (pick < 93)
            r.address = '0;
         else if (pick < 96)
            r.address = region_base + 32'(n + $urandom_range(0, 3)) * 32'(slot_bytes);
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= 100)
         $display("%0t mismatch %s: got 0x%08h want 0x%08h", $realtime, what, got, want);
   endtask

   task automatic queue_request(logic kind, logic [31:0] address);
      cache_request_type r;
      r.kind = kind;
      r.address = address;
      cache_requests.push_back(r);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (cache_requests.size() != 0 || req_tvalid || expected_results.size() != 0);
   endtask

   task automatic write_csr(logic [1:0] index, logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         fsoa_pkg::CSR_ENABLED:      cache_on = value[0];
         fsoa_pkg::CSR_BASE_ADDRESS: region_base = value;
         fsoa_pkg::CSR_OBJECT_SIZE:  slot_bytes = value[15:0];
         fsoa_pkg::CSR_SLOT_COUNT:   slot_limit = value[6:0];
         default: ;
      endcase
   endtask

   task automatic set_cache(logic en, logic [31:0] base, logic [15:0] size, logic [6:0] count);
      wait_idle();
      repeat (8) @(posedge clock);
      write_csr(fsoa_pkg::CSR_ENABLED, {31'd0, en});
      write_csr(fsoa_pkg::CSR_BASE_ADDRESS, base);
      write_csr(fsoa_pkg::CSR_OBJECT_SIZE, {16'd0, size});
      write_csr(fsoa_pkg::CSR_SLOT_COUNT, {25'd0, count});
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   always @(posedge clock) begin : driver
      cache_request_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(predict_cache_result(req_tuser, req_tdata));
            send_gap = idling_on ? gap_length() : 0;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (cache_requests.size() != 0) begin
               item = cache_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= item.address;
               req_tuser <= item.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      cache_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_tdata[34:3], '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[2:0] != want.status)
                  report_mismatch("status", 32'(rsp_tdata[2:0]), 32'(want.status));
               if (rsp_tdata[34:3] != want.object_address)
                  report_mismatch("object_address", rsp_tdata[34:3], want.object_address);
               if (rsp_tdata[41:35] != want.free_count)
                  report_mismatch("free_count", 32'(rsp_tdata[41:35]), 32'(want.free_count));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (idling_on && $urandom_range(0, 3) == 0)
               stall_left = gap_length();
            rsp_tready <= (stall_left == 0);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_WALL) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic [31:0] b;
      logic [15:0] s;
      logic [6:0]  c;
      for (int i = 0; i < SLOTS; i++) slot_taken[i] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // disabled after reset
      queue_request(fsoa_pkg::KIND_ALLOC, '0);
      queue_request(fsoa_pkg::KIND_FREE, 32'h40);

      // three widest slots: fill, overflow, free checks
      b = 32'h0001_0000;
      s = 16'hFFFF;
      set_cache(1'b1, b, s, 7'd3);
      repeat (4) queue_request(fsoa_pkg::KIND_ALLOC, 32'hFFFF_FFFF);
      queue_request(fsoa_pkg::KIND_FREE, b + 32'(s));
      queue_request(fsoa_pkg::KIND_FREE, b + 32'(s));
      queue_request(fsoa_pkg::KIND_FREE, '0);
      queue_request(fsoa_pkg::KIND_FREE, b + 32'd1);
      queue_request(fsoa_pkg::KIND_FREE, b + 3 * 32'(s));
      queue_request(fsoa_pkg::KIND_FREE, b - 32'(s));
      queue_request(fsoa_pkg::KIND_ALLOC, '0);

      // shrink the count: upper used bits stay but drop out of view
      set_cache(1'b1, b, s, 7'd1);
      queue_request(fsoa_pkg::KIND_ALLOC, '0);
      queue_request(fsoa_pkg::KIND_FREE, b + 2 * 32'(s));
      set_cache(1'b1, b, s, 7'd3);
      queue_request(fsoa_pkg::KIND_FREE, b + 2 * 32'(s));

      // region wraps past the top of the address space
      b = 32'hFFFF_FF00;
      set_cache(1'b1, b, 16'h0080, 7'd4);
      queue_request(fsoa_pkg::KIND_ALLOC, '0);
      queue_request(fsoa_pkg::KIND_ALLOC, '0);
      queue_request(fsoa_pkg::KIND_FREE, 32'h0000_0080);
      queue_request(fsoa_pkg::KIND_FREE, '0);

      // zero object size
      set_cache(1'b1, b, 16'd0, 7'd4);
      queue_request(fsoa_pkg::KIND_ALLOC, '0);
      queue_request(fsoa_pkg::KIND_FREE, b);

      // slot count above the built maximum
      set_cache(1'b1, b, 16'd1, 7'd100);
      queue_request(fsoa_pkg::KIND_ALLOC, '0);
      queue_request(fsoa_pkg::KIND_FREE, b + 32'd4);

      set_cache(1'b0, b, 16'd1, 7'd100);
      queue_request(fsoa_pkg::KIND_ALLOC, '0);

      for (int phase = 0; phase < 10; phase++) begin
         case (phase % 5)
            0: begin s = 16'd1; c = 7'd64; end
            1: begin s = 16'hFFFF; c = 7'($urandom_range(1, 8)); end
            2: begin s = 16'($urandom_range(1, 256)); c = 7'($urandom_range(1, 16)); end
            3: begin s = 16'($urandom_range(1, 65535)); c = 7'($urandom_range(0, 64)); end
            default: begin s = 16'($urandom_range(1, 64)); c = 7'($urandom_range(65, 127)); end
         endcase
         if (phase == 0)
            b = '0;
         else if (phase == 5)
            b = 32'hFFFF_FFFF;
         else
            b = $urandom;
         if (phase == 3) c = 7'd0;
         set_cache(phase != 7, b, s, c);
         idling_on = (phase % 4 != 3);
         if (phase == 2) hold_left = 400;
         repeat ($urandom_range(95, 110)) cache_requests.push_back(random_request());
      end

      wait_idle();
      repeat (60) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("missing transactions", '0, 32'(expected_results.size()));
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
